### hdl/schrage_rpq_scheduler_macros.svh
// Assertion macros shared by the Schrage scheduler RTL.
`ifndef SCHRAGE_RPQ_SCHEDULER_MACROS_SVH
`define SCHRAGE_RPQ_SCHEDULER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SRPQ_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SRPQ_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### hdl/srpq_pkg.sv
// Types and constants of the Schrage single-machine scheduler.
package srpq_pkg;

   localparam int FIELD_W = 16;
   localparam int TIME_W  = 22;
   localparam int NUM_W   = 5;
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   typedef struct packed {
      logic [FIELD_W-1:0] release_time;
      logic [FIELD_W-1:0] processing_time;
      logic [FIELD_W-1:0] tail_time;
      logic               last_job;
   } req_item_type;

   typedef struct packed {
      logic [NUM_W-1:0]  job_number;
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] makespan;
      logic              end_of_schedule;
      logic              overflow_flag;
   } rsp_item_type;

   typedef enum logic [2:0] {
      S_LOAD,
      S_SCAN,
      S_CALC,
      S_MARK,
      S_EMIT
   } state_type;

endpackage

### hdl/schrage_rpq_scheduler.sv
// Schrage heuristic scheduler for one machine with release, processing and tail times.
//
// Usage: jobs enter on the req_ channel one item per cycle while req_ready is high and are
// numbered from 0 in arrival order. Up to MAX_JOBS are stored; later jobs are dropped and
// flagged on the final result. The item with last_job set starts scheduling: req_ready
// drops and one rsp_ item comes out per stored job, in schedule order. The final item has
// end_of_schedule set and carries the makespan and the overflow flag.
// Sequence: each scheduled job costs one pass over the job memory through its single
// registered read port (n reads for n stored jobs), then the time arithmetic (S_CALC),
// the makespan update (S_MARK) and the output state (S_EMIT).
// Stalls: a result waits in the output register while rsp_ready is low; the scan for the
// next job starts only after it is taken. After the final result is taken, req_ready
// returns high and a new set may load.
// Reset: synchronous, active high; clears job count, done mask, time, makespan and the
// overflow flag and returns to loading. The job memory is not cleared: only entries of
// the current set are read.
module schrage_rpq_scheduler #(
   parameter int MAX_JOBS  = 32,
   parameter int TIME_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  srpq_pkg::req_item_type      req_item,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output srpq_pkg::rsp_item_type      rsp_item
);

`include "schrage_rpq_scheduler_macros.svh"

   localparam int SW = (TIME_BITS < srpq_pkg::FIELD_W) ? TIME_BITS : srpq_pkg::FIELD_W;
   localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CW = $clog2(MAX_JOBS + 1);
   localparam int TW = srpq_pkg::TIME_W;

   typedef struct packed {
      logic [SW-1:0] rel;
      logic [SW-1:0] proc;
      logic [SW-1:0] tail;
   } entry_type;

   // saturate a 23-bit sum to the 22-bit time range
   function automatic logic [TW-1:0] sat_time(input logic [TW:0] v);
      sat_time = v[TW] ? srpq_pkg::TIME_MAX : v[TW-1:0];
   endfunction

   entry_type jobs_mem [MAX_JOBS];
   entry_type rd_data_ff;
   entry_type wr_data;
   logic      mem_we;

   srpq_pkg::state_type    state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   ovf_ff, ovf_in;
   logic [MAX_JOBS-1:0]    done_ff, done_in;
   logic [TW-1:0]          cur_ff, cur_in;
   logic [TW-1:0]          ms_ff, ms_in;
   logic [CW-1:0]          sched_ff, sched_in;
   logic                   last_ff, last_in;
   logic [CW-1:0]          issue_ff, issue_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic                   rd_last_ff, rd_last_in;
   logic [IW-1:0]          rd_idx_ff, rd_idx_in;
   logic                   any_ready_ff, any_ready_in;
   logic [IW-1:0]          best_idx_ff, best_idx_in;
   logic [SW-1:0]          best_tail_ff, best_tail_in;
   logic [SW-1:0]          best_proc_ff, best_proc_in;
   logic                   min_valid_ff, min_valid_in;
   logic [IW-1:0]          min_idx_ff, min_idx_in;
   logic [SW-1:0]          min_rel_ff, min_rel_in;
   logic [SW-1:0]          min_tail_ff, min_tail_in;
   logic [SW-1:0]          min_proc_ff, min_proc_in;
   logic [IW-1:0]          pick_ff, pick_in;
   logic [SW-1:0]          pick_tail_ff, pick_tail_in;
   srpq_pkg::rsp_item_type rsp_ff, rsp_in;

   logic [IW-1:0] sel_idx;
   logic [TW-1:0] sel_start;
   logic [SW-1:0] sel_proc;
   logic [SW-1:0] sel_tail;
   logic [TW-1:0] deliver;
   logic [TW-1:0] ms_new;

   assign wr_data.rel  = req_item.release_time[SW-1:0];
   assign wr_data.proc = req_item.processing_time[SW-1:0];
   assign wr_data.tail = req_item.tail_time[SW-1:0];

   // job memory: one write port at the load count, one registered read port for the scan
   always_ff @(posedge clock) begin
      if (mem_we) begin
         jobs_mem[count_ff[IW-1:0]] <= wr_data;
      end
      rd_data_ff <= jobs_mem[issue_ff[IW-1:0]];
   end

   // selection of the next job from the scan results
   always_comb begin
      sel_idx   = any_ready_ff ? best_idx_ff : min_idx_ff;
      sel_start = any_ready_ff ? cur_ff : TW'(min_rel_ff);
      sel_proc  = any_ready_ff ? best_proc_ff : min_proc_ff;
      sel_tail  = any_ready_ff ? best_tail_ff : min_tail_ff;
      deliver   = sat_time({1'b0, cur_ff} + (TW + 1)'(pick_tail_ff));
      ms_new    = (deliver > ms_ff) ? deliver : ms_ff;
   end

   // sequencer: next state and datapath control
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      done_in      = done_ff;
      cur_in       = cur_ff;
      ms_in        = ms_ff;
      sched_in     = sched_ff;
      last_in      = last_ff;
      issue_in     = issue_ff;
      rd_valid_in  = 1'b0;
      rd_last_in   = 1'b0;
      rd_idx_in    = issue_ff[IW-1:0];
      any_ready_in = any_ready_ff;
      best_idx_in  = best_idx_ff;
      best_tail_in = best_tail_ff;
      best_proc_in = best_proc_ff;
      min_valid_in = min_valid_ff;
      min_idx_in   = min_idx_ff;
      min_rel_in   = min_rel_ff;
      min_tail_in  = min_tail_ff;
      min_proc_in  = min_proc_ff;
      pick_in      = pick_ff;
      pick_tail_in = pick_tail_ff;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;

      case (state_ff)
         // take in jobs until the one marked last
         srpq_pkg::S_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (count_ff != CW'(MAX_JOBS)) begin
                  mem_we   = 1'b1;
                  count_in = count_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_item.last_job) begin
                  state_in     = srpq_pkg::S_SCAN;
                  issue_in     = '0;
                  any_ready_in = 1'b0;
                  min_valid_in = 1'b0;
               end
            end
         end

         // one pass over the stored jobs, one read a cycle
         srpq_pkg::S_SCAN: begin
            if (issue_ff != count_ff) begin
               issue_in    = issue_ff + 1'b1;
               rd_valid_in = 1'b1;
               rd_last_in  = (CW'(issue_ff + 1'b1) == count_ff);
            end
            if (rd_valid_ff && !done_ff[rd_idx_ff]) begin
               // released jobs: largest tail, lowest number on a tie
               if (TW'(rd_data_ff.rel) <= cur_ff) begin
                  any_ready_in = 1'b1;
                  if (!any_ready_ff || rd_data_ff.tail > best_tail_ff) begin
                     best_idx_in  = rd_idx_ff;
                     best_tail_in = rd_data_ff.tail;
                     best_proc_in = rd_data_ff.proc;
                  end
               end
               // earliest release: largest tail among those, for a time jump
               if (!min_valid_ff || rd_data_ff.rel < min_rel_ff ||
                   (rd_data_ff.rel == min_rel_ff && rd_data_ff.tail > min_tail_ff)) begin
                  min_valid_in = 1'b1;
                  min_idx_in   = rd_idx_ff;
                  min_rel_in   = rd_data_ff.rel;
                  min_tail_in  = rd_data_ff.tail;
                  min_proc_in  = rd_data_ff.proc;
               end
            end
            if (rd_valid_ff && rd_last_ff) begin
               state_in = srpq_pkg::S_CALC;
            end
         end

         // commit the pick and set time to its start plus its processing time
         srpq_pkg::S_CALC: begin
            pick_in           = sel_idx;
            pick_tail_in      = sel_tail;
            done_in           = done_ff | (MAX_JOBS'(1) << sel_idx);
            cur_in            = sat_time({1'b0, sel_start} + (TW + 1)'(sel_proc));
            sched_in          = sched_ff + 1'b1;
            last_in           = (CW'(sched_ff + 1'b1) == count_ff);
            rsp_in.job_number = srpq_pkg::NUM_W'(sel_idx);
            rsp_in.start_time = sel_start;
            state_in          = srpq_pkg::S_MARK;
         end

         // fold completion plus tail into the makespan, finish the item
         srpq_pkg::S_MARK: begin
            ms_in                  = ms_new;
            rsp_in.makespan        = last_ff ? ms_new : '0;
            rsp_in.end_of_schedule = last_ff;
            rsp_in.overflow_flag   = last_ff & ovf_ff;
            state_in               = srpq_pkg::S_EMIT;
         end

         // hold the item until taken
         srpq_pkg::S_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (last_ff) begin
                  state_in = srpq_pkg::S_LOAD;
                  count_in = '0;
                  ovf_in   = 1'b0;
                  done_in  = '0;
                  cur_in   = '0;
                  ms_in    = '0;
                  sched_in = '0;
                  last_in  = 1'b0;
               end else begin
                  state_in     = srpq_pkg::S_SCAN;
                  issue_in     = '0;
                  any_ready_in = 1'b0;
                  min_valid_in = 1'b0;
               end
            end
         end

         default: begin
            state_in = srpq_pkg::S_LOAD;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= srpq_pkg::S_LOAD;
         count_ff    <= '0;
         ovf_ff      <= 1'b0;
         done_ff     <= '0;
         cur_ff      <= '0;
         ms_ff       <= '0;
         sched_ff    <= '0;
         last_ff     <= 1'b0;
         issue_ff    <= '0;
         rd_valid_ff <= 1'b0;
         rd_last_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         ovf_ff      <= ovf_in;
         done_ff     <= done_in;
         cur_ff      <= cur_in;
         ms_ff       <= ms_in;
         sched_ff    <= sched_in;
         last_ff     <= last_in;
         issue_ff    <= issue_in;
         rd_valid_ff <= rd_valid_in;
         rd_last_ff  <= rd_last_in;
      end
   end

   // scan trackers and output payload
   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      any_ready_ff <= any_ready_in;
      best_idx_ff  <= best_idx_in;
      best_tail_ff <= best_tail_in;
      best_proc_ff <= best_proc_in;
      min_valid_ff <= min_valid_in;
      min_idx_ff   <= min_idx_in;
      min_rel_ff   <= min_rel_in;
      min_tail_ff  <= min_tail_in;
      min_proc_ff  <= min_proc_in;
      pick_ff      <= pick_in;
      pick_tail_ff <= pick_tail_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_item = rsp_ff;

   // checks
   `SRPQ_ASSERT_NOW(a_no_load_while_out, clock, reset, req_ready, !rsp_valid)
   `SRPQ_ASSERT_NOW(a_count_in_range, clock, reset, 1'b1, count_ff <= CW'(MAX_JOBS))
   `SRPQ_ASSERT_NOW(a_pick_marked_done, clock, reset, rsp_valid, done_ff[pick_ff])
   `SRPQ_ASSERT_NEXT(a_set_cleared, clock, reset,
                     rsp_valid && rsp_ready && rsp_item.end_of_schedule,
                     req_ready && count_ff == '0 && done_ff == '0)

endmodule
